@@ sv/mbd_pkg.sv @@
// shared types and constants for the mipmap box downsampler
`timescale 1ns / 1ps
`default_nettype none

package mbd_pkg;

  localparam int MaxSize   = 2048;
  localparam int LineDepth = MaxSize / 2;
  localparam int AddrW     = $clog2(LineDepth);
  localparam int CntW      = $clog2(MaxSize);
  localparam int DimW      = CntW + 1;
  localparam int CfgW      = 12;
  localparam int CfgIdxW   = 2;
  localparam int NumLanes  = 4;
  localparam int PixW      = 8;
  localparam int PairW     = PixW + 1;
  localparam int LineW     = PairW * NumLanes;

  typedef enum logic [CfgIdxW-1:0] {
    RegSrcWidth  = 2'd0,
    RegSrcHeight = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [PixW-1:0] in_c0;
    logic [PixW-1:0] in_c1;
    logic [PixW-1:0] in_c2;
    logic [PixW-1:0] in_c3;
  } in_t;

  typedef struct packed {
    logic [PixW-1:0] out_c0;
    logic [PixW-1:0] out_c1;
    logic [PixW-1:0] out_c2;
    logic [PixW-1:0] out_c3;
    logic            level_done;
  } out_t;

  // pipeline enables shared by all lanes
  typedef struct packed {
    logic load_partial;
    logic s1_load;
    logic s2_load;
    logic out_load;
    logic w1;
    logic h1;
    logic last;
  } ctl_t;

  typedef struct packed {
    logic             we;
    logic             re;
    logic [AddrW-1:0] addr;
  } ram_ctl_t;

endpackage

`default_nettype wire

@@ sv/mipmap_box_downsampler.sv @@
// top level of the 2x2 box filter mip level downsampler
`timescale 1ns / 1ps
`default_nettype none

// Takes one four-channel pixel per transaction in raster order of a source mip
// level (dimensions set by src_width and src_height) and returns the pixels of
// the next level, each channel the truncated mean of a 2x2 block; level_done
// marks the last one. It accepts one pixel every cycle with no gaps, as long as
// the output side keeps up; the pixel that completes a block moves its result
// through the pair register, line store read and output register. Even
// row pair sums live in one 1024 x 36 line store with one write and one read
// port, and the four channels run in parallel lanes. Write the registers only
// while the block is idle; each write restarts the level.
module mipmap_box_downsampler (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [mbd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [mbd_pkg::CfgW-1:0]    cfg_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire mbd_pkg::in_t                in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output mbd_pkg::out_t                    out_data_o
);

  localparam int PixW  = mbd_pkg::PixW;
  localparam int PairW = mbd_pkg::PairW;

  mbd_pkg::ctl_t             ctl;
  mbd_pkg::ram_ctl_t         ram;
  mbd_pkg::out_t             out_q;
  logic [PixW-1:0]           px  [mbd_pkg::NumLanes];
  logic [PixW-1:0]           res [mbd_pkg::NumLanes];
  logic [mbd_pkg::LineW-1:0] line_wdata, line_rdata;

  mbd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .ctl_o       (ctl),
    .ram_o       (ram)
  );

  assign px[0] = in_data_i.in_c0;
  assign px[1] = in_data_i.in_c1;
  assign px[2] = in_data_i.in_c2;
  assign px[3] = in_data_i.in_c3;

  for (genvar i = 0; i < mbd_pkg::NumLanes; i++) begin : g_lane
    mbd_lane u_lane (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .px_i   (px[i]),
      .line_i (line_rdata[i*PairW +: PairW]),
      .pair_o (line_wdata[i*PairW +: PairW]),
      .res_o  (res[i])
    );
  end

  mbd_ram #(
    .Width (mbd_pkg::LineW),
    .Depth (mbd_pkg::LineDepth)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (ram.we),
    .waddr_i (ram.addr),
    .wdata_i (line_wdata),
    .re_i    (ram.re),
    .raddr_i (ram.addr),
    .rdata_o (line_rdata)
  );

  // merge the lane results into the output register
  always_ff @(posedge clk_i) begin
    if (ctl.out_load) begin
      out_q.out_c0     <= res[0];
      out_q.out_c1     <= res[1];
      out_q.out_c2     <= res[2];
      out_q.out_c3     <= res[3];
      out_q.level_done <= ctl.last;
    end
  end

  assign out_data_o = out_q;

`ifndef SYNTHESIS
  // even rows write the line store, odd rows read it, never both at once
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(ram.we && ram.re))
    else $error("line store written and read in the same cycle");

  // a 1x1 source never forms a pair
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl.w1 && ctl.h1 && ctl.s1_load))
    else $error("pair formed for a 1x1 source");

  // one pixel is either the left half of a pair or completes one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl.load_partial && ctl.s1_load))
    else $error("pixel both starts and completes a pair");
`endif

endmodule

`default_nettype wire

@@ sv/mbd_ram.sv @@
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module mbd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ sv/mbd_lane.sv @@
// one channel lane: horizontal pair sum, vertical sum and truncated mean
`timescale 1ns / 1ps
`default_nettype none

module mbd_lane (
  input  wire logic                      clk_i,
  input  wire mbd_pkg::ctl_t             ctl_i,
  input  wire logic [mbd_pkg::PixW-1:0]  px_i,
  input  wire logic [mbd_pkg::PairW-1:0] line_i,
  output logic      [mbd_pkg::PairW-1:0] pair_o,
  output logic      [mbd_pkg::PixW-1:0]  res_o
);

  logic [mbd_pkg::PixW-1:0]  partial_q;
  logic [mbd_pkg::PairW-1:0] pair1_d, pair1_q, pair2_q;
  logic [mbd_pkg::PairW:0]   sum;

  // width of one: the pixel is its own horizontal partner
  assign pair1_d = ctl_i.w1 ? {px_i, 1'b0}
                            : {1'b0, partial_q} + {1'b0, px_i};

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_partial) begin
      partial_q <= px_i;
    end
    if (ctl_i.s1_load) begin
      pair1_q <= pair1_d;
    end
    if (ctl_i.s2_load) begin
      pair2_q <= pair1_q;
    end
  end

  // height of one: the pair is its own vertical partner
  assign sum    = ctl_i.h1 ? {pair2_q, 1'b0} : {1'b0, line_i} + {1'b0, pair2_q};
  assign res_o  = sum[mbd_pkg::PairW:2];
  assign pair_o = pair1_q;

endmodule

`default_nettype wire

@@ sv/mbd_ctrl.sv @@
// dimension registers, raster counters and pipeline control
`timescale 1ns / 1ps
`default_nettype none

module mbd_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [mbd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [mbd_pkg::CfgW-1:0]    cfg_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        out_ready_i,
  output logic                             out_valid_o,
  output mbd_pkg::ctl_t                    ctl_o,
  output mbd_pkg::ram_ctl_t                ram_o
);

  localparam int CntW  = mbd_pkg::CntW;
  localparam int DimW  = mbd_pkg::DimW;
  localparam int AddrW = mbd_pkg::AddrW;

  logic [DimW-1:0]  w_q, h_q, dim_clamped;
  logic [CntW-1:0]  col_q, col_d, row_q, row_d;
  logic [DimW-1:0]  col_inc, row_inc;
  logic [31:0]      cfg_wide;
  logic             cfg_hit;

  logic             w1, h1, both;
  logic [CntW-1:0]  nw, nh;
  logic [AddrW-1:0] x, y;
  logic             x_ok, y_ok, pair_ok, ld_part, emit, wr, last;

  logic             in_fire, s1_go, s1_load, s2_load, out_load;
  logic             s2_free, out_free;
  logic             s1_valid_q, s1_emit_q, s1_wr_q, s1_last_q;
  logic [AddrW-1:0] s1_x_q;
  logic             s2_valid_q, s2_last_q, out_valid_q;

  // register value of zero acts as one, above the maximum as the maximum
  assign cfg_wide = 32'(cfg_data_i);
  always_comb begin
    if (cfg_wide == 32'd0) begin
      dim_clamped = DimW'(1);
    end else if (cfg_wide > 32'(mbd_pkg::MaxSize)) begin
      dim_clamped = DimW'(mbd_pkg::MaxSize);
    end else begin
      dim_clamped = cfg_wide[DimW-1:0];
    end
  end

  always_comb begin
    case (mbd_pkg::cfg_reg_e'(cfg_idx_i))
      mbd_pkg::RegSrcWidth:  cfg_hit = cfg_we_i;
      mbd_pkg::RegSrcHeight: cfg_hit = cfg_we_i;
      default:               cfg_hit = 1'b0;
    endcase
  end

  assign w1   = (w_q == DimW'(1));
  assign h1   = (h_q == DimW'(1));
  assign both = w1 & h1;
  assign nw   = w1 ? CntW'(1) : w_q[DimW-1:1];
  assign nh   = h1 ? CntW'(1) : h_q[DimW-1:1];

  assign x    = w1 ? '0 : col_q[CntW-1:1];
  assign y    = h1 ? '0 : row_q[CntW-1:1];
  assign x_ok = w1 | ({1'b0, x} < nw);
  assign y_ok = h1 | ({1'b0, y} < nh);
  assign last = ({1'b0, x} == nw - CntW'(1)) && ({1'b0, y} == nh - CntW'(1));

  // trailing odd column or row falls outside x_ok / y_ok and is dropped
  assign pair_ok = ~both & (w1 | (x_ok & col_q[0]));
  assign ld_part = ~both & ~w1 & x_ok & ~col_q[0];
  assign emit    = h1 | (y_ok & row_q[0]);
  assign wr      = ~h1 & y_ok & ~row_q[0];

  // pipeline: s1 holds a pair, s2 waits on the line read, then the output register
  assign out_free   = ~out_valid_q | out_ready_i;
  assign out_load   = s2_valid_q & out_free;
  assign s2_free    = ~s2_valid_q | out_free;
  assign s1_go      = s1_valid_q & (~s1_emit_q | s2_free);
  assign s2_load    = s1_go & s1_emit_q;
  assign in_ready_o = ~s1_valid_q | s1_go;
  assign in_fire    = in_valid_i & in_ready_o;
  assign s1_load    = in_fire & pair_ok;

  assign col_inc = {1'b0, col_q} + DimW'(1);
  assign row_inc = {1'b0, row_q} + DimW'(1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_hit) begin
      col_d = '0;
      row_d = '0;
    end else if (in_fire) begin
      if (col_inc >= w_q) begin
        col_d = '0;
        row_d = (row_inc >= h_q) ? '0 : row_inc[CntW-1:0];
      end else begin
        col_d = col_inc[CntW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q         <= DimW'(1);
      h_q         <= DimW'(1);
      col_q       <= '0;
      row_q       <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_hit && cfg_idx_i == mbd_pkg::RegSrcWidth) begin
        w_q <= dim_clamped;
      end
      if (cfg_hit && cfg_idx_i == mbd_pkg::RegSrcHeight) begin
        h_q <= dim_clamped;
      end
      col_q       <= col_d;
      row_q       <= row_d;
      s1_valid_q  <= s1_load | (s1_valid_q & ~s1_go);
      s2_valid_q  <= s2_load | (s2_valid_q & ~out_load);
      out_valid_q <= out_load | (out_valid_q & ~out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_emit_q <= emit;
      s1_wr_q   <= wr;
      s1_last_q <= last;
      s1_x_q    <= x;
    end
    if (s2_load) begin
      s2_last_q <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;

  assign ctl_o.load_partial = in_fire & ld_part;
  assign ctl_o.s1_load      = s1_load;
  assign ctl_o.s2_load      = s2_load;
  assign ctl_o.out_load     = out_load;
  assign ctl_o.w1           = w1;
  assign ctl_o.h1           = h1;
  assign ctl_o.last         = s2_last_q;

  assign ram_o.we   = s1_go & s1_wr_q;
  assign ram_o.re   = s2_load & ~h1;
  assign ram_o.addr = s1_x_q;

endmodule

`default_nettype wire

@@ test/tb.sv @@
// testbench for the mipmap box downsampler with a self-checking box filter predictor
`timescale 1ns / 1ps

module tb;
  import mbd_pkg::*;

  localparam int QuietLimit  = 2000;
  localparam int PipeDrain   = 6;
  localparam int RandomItems = 270;

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i  = '0;
  logic [CfgW-1:0]     cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  in_t                 in_data_i  = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_t                out_data_o;

  mipmap_box_downsampler u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state
  logic [PairW-1:0] pair_line [LineDepth][NumLanes];
  logic [PixW-1:0]  lane_hold [NumLanes];
  int unsigned      col_pos;
  int unsigned      row_pos;
  logic [CfgW-1:0]  src_w_reg;
  logic [CfgW-1:0]  src_h_reg;
  out_t             box_means_q [$];

  int  err_count;
  int  quiet_cycles;
  int  ready_wait;
  bit  in_fire;
  bit  out_fire;
  bit  pixel_rush;
  bit  ready_rush;

  function automatic int unsigned eff_dim(input logic [CfgW-1:0] v);
    if (v == 0) return 1;
    if (v > MaxSize) return MaxSize;
    return v;
  endfunction

  function automatic void reduce_pixel(input in_t px);
    int unsigned       w, h, nw, nh, x, y;
    logic [PixW-1:0]   lane [NumLanes];
    logic [PairW-1:0]  pair [NumLanes];
    logic [PairW:0]    total [NumLanes];
    bit                have_pair;
    bit                emit;
    out_t              res;
    w  = eff_dim(src_w_reg);
    h  = eff_dim(src_h_reg);
    nw = (w / 2 < 1) ? 1 : w / 2;
    nh = (h / 2 < 1) ? 1 : h / 2;
    lane[0] = px.in_c0;
    lane[1] = px.in_c1;
    lane[2] = px.in_c2;
    lane[3] = px.in_c3;
    have_pair = 1'b0;
    emit = 1'b0;
    x = 0;
    y = 0;
    if (!(w == 1 && h == 1)) begin
      if (w == 1) begin
        // single column pairs each pixel with itself
        for (int c = 0; c < NumLanes; c++) pair[c] = {lane[c], 1'b0};
        have_pair = 1'b1;
      end else begin
        x = col_pos / 2;
        if (x < nw) begin
          if (col_pos % 2 == 0) begin
            for (int c = 0; c < NumLanes; c++) lane_hold[c] = lane[c];
          end else begin
            for (int c = 0; c < NumLanes; c++) pair[c] = PairW'(lane_hold[c]) + PairW'(lane[c]);
            have_pair = 1'b1;
          end
        end
      end
      if (have_pair) begin
        if (h == 1) begin
          for (int c = 0; c < NumLanes; c++) total[c] = {pair[c], 1'b0};
          emit = 1'b1;
        end else begin
          y = row_pos / 2;
          if (y < nh) begin
            if (row_pos % 2 == 0) begin
              for (int c = 0; c < NumLanes; c++) pair_line[x][c] = pair[c];
            end else begin
              for (int c = 0; c < NumLanes; c++) begin
                total[c] = (PairW + 1)'(pair_line[x][c]) + (PairW + 1)'(pair[c]);
              end
              emit = 1'b1;
            end
          end
        end
        if (emit) begin
          res.out_c0     = total[0][PairW:2];
          res.out_c1     = total[1][PairW:2];
          res.out_c2     = total[2][PairW:2];
          res.out_c3     = total[3][PairW:2];
          res.level_done = (x == nw - 1) && (y == nh - 1);
          box_means_q.push_back(res);
        end
      end
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endfunction

  function automatic in_t rand_pixel();
    logic [PixW-1:0] lane [NumLanes];
    int unsigned     r;
    for (int c = 0; c < NumLanes; c++) begin
      r = $urandom_range(0, 7);
      lane[c] = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(0, 255));
    end
    return {lane[0], lane[1], lane[2], lane[3]};
  endfunction

  function automatic logic [CfgW-1:0] rand_dim();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return CfgW'($urandom_range(0, 8));
    if (r < 8) return CfgW'($urandom_range(9, 24));
    if (r < 9) return CfgW'($urandom_range(25, 64));
    // above the maximum, acts as the largest size
    return CfgW'($urandom_range(MaxSize + 1, 4095));
  endfunction

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      err_count++;
    end
  endtask

  // transaction flags sampled mid-cycle, consumed at the next rising edge
  always @(negedge clk_i) begin : result_check
    out_t want;
    in_fire  = rst_ni && in_valid_i && in_ready_o;
    out_fire = rst_ni && out_valid_o && out_ready_i;
    if (out_fire) begin
      if (box_means_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, out_data_o);
        err_count++;
      end else begin
        want = box_means_q.pop_front();
        check_field("out_c0", want.out_c0, out_data_o.out_c0);
        check_field("out_c1", want.out_c1, out_data_o.out_c1);
        check_field("out_c2", want.out_c2, out_data_o.out_c2);
        check_field("out_c3", want.out_c3, out_data_o.out_c3);
        check_field("level_done", want.level_done, out_data_o.level_done);
      end
    end
  end

  always @(posedge clk_i) begin : result_drain
    int unsigned stall;
    if (out_fire) begin
      stall = ready_rush ? 0 : $urandom_range(0, 9);
      if (stall == 0) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b0;
        ready_wait  <= stall;
      end
    end else if (!out_ready_i) begin
      if (ready_wait <= 1) begin
        out_ready_i <= 1'b1;
        ready_wait  <= 0;
      end else begin
        ready_wait <= ready_wait - 1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (in_fire || out_fire || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // valid stays high across back-to-back transactions
  task automatic send_pixel(input in_t px);
    int unsigned gap;
    gap = pixel_rush ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    do @(posedge clk_i); while (!in_fire);
    reduce_pixel(px);
  endtask

  task automatic send_pixels(input int n);
    repeat (n) send_pixel(rand_pixel());
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (box_means_q.size() != 0) @(posedge clk_i);
    repeat (PipeDrain) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    if (idx == RegSrcWidth) src_w_reg = val;
    else src_h_reg = val;
    col_pos = 0;
    row_pos = 0;
  endtask

  task automatic set_dims(input logic [CfgW-1:0] w, input logic [CfgW-1:0] h,
                          input bit do_w, input bit do_h);
    bit w_first;
    w_first = 1'($urandom_range(0, 1));
    if (do_w && w_first) write_reg(RegSrcWidth, w);
    if (do_h) write_reg(RegSrcHeight, h);
    if (do_w && !w_first) write_reg(RegSrcWidth, w);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_special_sizes();
    pixel_rush = 1'b0;
    ready_rush = 1'b0;
    // zero acts as one: a 1x1 source gives nothing, extra pixels wrap
    set_dims(12'd0, 12'd0, 1'b1, 1'b1);
    send_pixel('1);
    send_pixel('0);
    settle();
    // odd width and height, first block saturated
    set_dims(12'd3, 12'd3, 1'b1, 1'b1);
    for (int i = 0; i < 9; i++) send_pixel((i % 3 != 2) ? in_t'('1) : rand_pixel());
    settle();
    set_dims(12'd1, 12'd4, 1'b1, 1'b1);
    repeat (4) send_pixel('0);
    settle();
    set_dims(12'd4, 12'd1, 1'b1, 1'b1);
    send_pixels(2);
    settle();
    // rewrite restarts the level mid row
    set_dims(12'd4, 12'd1, 1'b1, 1'b0);
    send_pixels(4);
    settle();
  endtask

  // oversized and largest dimensions, start of the level only
  task automatic test_max_sizes();
    pixel_rush = 1'($urandom_range(0, 1));
    ready_rush = 1'($urandom_range(0, 1));
    set_dims(12'hFFF, 12'd1, 1'b1, 1'b1);
    send_pixels(96);
    settle();
    pixel_rush = 1'($urandom_range(0, 1));
    ready_rush = 1'($urandom_range(0, 1));
    set_dims(12'd1, 12'hFFF, 1'b1, 1'b1);
    send_pixels(32);
    settle();
    pixel_rush = 1'($urandom_range(0, 1));
    ready_rush = 1'($urandom_range(0, 1));
    set_dims(12'h800, 12'h000, 1'b1, 1'b1);
    send_pixels(32);
    settle();
  endtask

  task automatic test_random_levels();
    int unsigned       level;
    int                n;
    int                random_items;
    logic [CfgW-1:0]   w, h;
    random_items = 0;
    while (random_items < RandomItems) begin
      w = rand_dim();
      h = rand_dim();
      pixel_rush = ($urandom_range(0, 3) == 0);
      ready_rush = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 7))
        0: set_dims(w, h, 1'b0, 1'b0);
        1: set_dims(w, h, 1'b1, 1'b0);
        2: set_dims(w, h, 1'b0, 1'b1);
        default: set_dims(w, h, 1'b1, 1'b1);
      endcase
      level = eff_dim(src_w_reg) * eff_dim(src_h_reg);
      // mostly whole levels, sometimes two in a row, else a cut-off level
      if ($urandom_range(0, 9) < 7 && level <= 200) n = level * $urandom_range(1, 2);
      else n = $urandom_range(1, 40);
      if (n > RandomItems - random_items) n = RandomItems - random_items;
      send_pixels(n);
      random_items += n;
      settle();
    end
  endtask

  initial begin
    err_count = 0;
    quiet_cycles = 0;
    ready_wait = 0;
    col_pos = 0;
    row_pos = 0;
    src_w_reg = 12'd1;
    src_h_reg = 12'd1;
    for (int c = 0; c < NumLanes; c++) lane_hold[c] = '0;
    pixel_rush = 1'b0;
    ready_rush = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_special_sizes();
    test_max_sizes();
    test_random_levels();
    settle();
    if (err_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
